FILE: rtl/l63eul_pkg.sv
// Package for the Lorenz-63 Euler step unit.
// Holds the default number format and the configuration register indexes.
// Depends on nothing.
`default_nettype none

package l63eul_pkg;

	localparam int DEFAULT_WORD_BITS = 32;
	localparam int DEFAULT_FRAC_BITS = 24;

	localparam int CFG_INDEX_BITS = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SIGMA = 2'd0,
		CFG_RHO   = 2'd1,
		CFG_BETA  = 2'd2,
		CFG_STEP  = 2'd3
	} cfg_index_t;

endpackage

`default_nettype wire

FILE: rtl/lorenz63_euler_step_unit.sv
// Lorenz-63 forward Euler step with additive perturbation, five-stage pipeline.
// An accepted input word moves through the stage registers s1 to s5 in order and leaves s5 as a valid output word.
// Throughput: one word per cycle while out_ready holds; a stalled output fills bubbles before input stalls.
// Reset: valid bits clear and the parameter registers return to their defaults.
// Depends on l63eul_pkg for the default format and the register indexes.
`default_nettype none

module lorenz63_euler_step_unit #(
	parameter int WORD_BITS = l63eul_pkg::DEFAULT_WORD_BITS,
	parameter int FRAC_BITS = l63eul_pkg::DEFAULT_FRAC_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire l63eul_pkg::cfg_index_t        cfg_index,
	input  wire logic        [WORD_BITS-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [WORD_BITS-1:0]   in_x,
	input  wire logic signed [WORD_BITS-1:0]   in_y,
	input  wire logic signed [WORD_BITS-1:0]   in_z,
	input  wire logic signed [WORD_BITS-1:0]   noise_x,
	input  wire logic signed [WORD_BITS-1:0]   noise_y,
	input  wire logic signed [WORD_BITS-1:0]   noise_z,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [WORD_BITS-1:0]        out_x,
	output logic signed [WORD_BITS-1:0]        out_y,
	output logic signed [WORD_BITS-1:0]        out_z,
	output logic                               overflow_flag
);
	import l63eul_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int W2 = 2 * WORD_BITS;

	localparam logic [63:0] ONE_FIX   = 64'd1 << FRAC_BITS;
	localparam logic [63:0] SIGMA_RST = 64'd10 << FRAC_BITS;
	localparam logic [63:0] RHO_RST   = 64'd28 << FRAC_BITS;
	localparam logic [63:0] BETA_RST  = (64'd16 * ONE_FIX + 64'd3) / 64'd6;
	localparam logic [63:0] STEP_RST  = (ONE_FIX + 64'd100) / 64'd200;

	typedef logic signed [W-1:0]  word_t;
	typedef logic signed [W2-1:0] wide_t;

	typedef struct packed {
		logic  ovf;
		word_t val;
	} sat_t;

	localparam word_t MAX_WORD = {1'b0, {(W-1){1'b1}}};
	localparam word_t MIN_WORD = {1'b1, {(W-1){1'b0}}};

	function automatic sat_t sat_fit(input wide_t v);
		sat_t r;
		r.ovf = !((&v[W2-1:W-1]) || !(|v[W2-1:W-1]));
		r.val = r.ovf ? (v[W2-1] ? MIN_WORD : MAX_WORD) : v[W-1:0];
		return r;
	endfunction

	function automatic sat_t sat_add(input word_t a, input word_t b);
		wide_t s;
		s = W2'(a) + W2'(b);
		return sat_fit(s);
	endfunction

	function automatic sat_t sat_sub(input word_t a, input word_t b);
		wide_t s;
		s = W2'(a) - W2'(b);
		return sat_fit(s);
	endfunction

	function automatic sat_t sat_mul(input word_t a, input word_t b);
		wide_t p;
		wide_t sh;
		p  = W2'(a) * W2'(b);
		sh = p >>> FRAC_BITS;
		return sat_fit(sh);
	endfunction

	// Parameter registers.
	word_t          sigma_q;
	word_t          rho_q;
	word_t          beta_q;
	logic [W-2:0]   step_q;
	word_t          dt_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= SIGMA_RST[W-1:0];
			rho_q   <= RHO_RST[W-1:0];
			beta_q  <= BETA_RST[W-1:0];
			step_q  <= STEP_RST[W-2:0];
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SIGMA: sigma_q <= cfg_data;
				CFG_RHO:   rho_q   <= cfg_data;
				CFG_BETA:  beta_q  <= cfg_data;
				CFG_STEP:  step_q  <= cfg_data[W-2:0];
				default: begin
				end
			endcase
		end
	end

	assign dt_w = {1'b0, step_q};

	// Stage enables: a stage loads when it is empty or the next one loads.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	assign en5 = !v_s5 || out_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// Stage 1: differences and the products that need only the input.
	sat_t  dxy_c, drz_c, mxy_c, mbz_c;
	word_t x_s1, y_s1, z_s1, nx_s1, ny_s1, nz_s1;
	word_t dxy_s1, drz_s1, mxy_s1, mbz_s1;
	logic  ovf_s1;

	always_comb begin
		dxy_c = sat_sub(in_y, in_x);
		drz_c = sat_sub(rho_q, in_z);
		mxy_c = sat_mul(in_x, in_y);
		mbz_c = sat_mul(beta_q, in_z);
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1   <= in_x;
			y_s1   <= in_y;
			z_s1   <= in_z;
			nx_s1  <= noise_x;
			ny_s1  <= noise_y;
			nz_s1  <= noise_z;
			dxy_s1 <= dxy_c.val;
			drz_s1 <= drz_c.val;
			mxy_s1 <= mxy_c.val;
			mbz_s1 <= mbz_c.val;
			ovf_s1 <= dxy_c.ovf | drz_c.ovf | mxy_c.ovf | mbz_c.ovf;
		end
	end

	// Stage 2: second products and the z derivative.
	sat_t  msx_c, mxr_c, ez_c;
	word_t x_s2, y_s2, z_s2, nx_s2, ny_s2, nz_s2;
	word_t msx_s2, mxr_s2, ez_s2;
	logic  ovf_s2;

	always_comb begin
		msx_c = sat_mul(sigma_q, dxy_s1);
		mxr_c = sat_mul(x_s1, drz_s1);
		ez_c  = sat_sub(mxy_s1, mbz_s1);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			z_s2   <= z_s1;
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
			nz_s2  <= nz_s1;
			msx_s2 <= msx_c.val;
			mxr_s2 <= mxr_c.val;
			ez_s2  <= ez_c.val;
			ovf_s2 <= ovf_s1 | msx_c.ovf | mxr_c.ovf | ez_c.ovf;
		end
	end

	// Stage 3: x and z increments, y derivative.
	sat_t  tx_c, tz_c, ey_c;
	word_t x_s3, y_s3, z_s3, nx_s3, ny_s3, nz_s3;
	word_t tx_s3, tz_s3, ey_s3;
	logic  ovf_s3;

	always_comb begin
		tx_c = sat_mul(msx_s2, dt_w);
		tz_c = sat_mul(ez_s2, dt_w);
		ey_c = sat_sub(mxr_s2, y_s2);
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			z_s3   <= z_s2;
			nx_s3  <= nx_s2;
			ny_s3  <= ny_s2;
			nz_s3  <= nz_s2;
			tx_s3  <= tx_c.val;
			tz_s3  <= tz_c.val;
			ey_s3  <= ey_c.val;
			ovf_s3 <= ovf_s2 | tx_c.ovf | tz_c.ovf | ey_c.ovf;
		end
	end

	// Stage 4: y increment, final x and z.
	sat_t  ty_c, ax_c, rx_c, az_c, rz_c;
	word_t y_s4, ny_s4, ty_s4, rx_s4, rz_s4;
	logic  ovf_s4;

	always_comb begin
		ty_c = sat_mul(ey_s3, dt_w);
		ax_c = sat_add(x_s3, tx_s3);
		rx_c = sat_add(ax_c.val, nx_s3);
		az_c = sat_add(z_s3, tz_s3);
		rz_c = sat_add(az_c.val, nz_s3);
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			y_s4   <= y_s3;
			ny_s4  <= ny_s3;
			ty_s4  <= ty_c.val;
			rx_s4  <= rx_c.val;
			rz_s4  <= rz_c.val;
			ovf_s4 <= ovf_s3 | ty_c.ovf | ax_c.ovf | rx_c.ovf | az_c.ovf | rz_c.ovf;
		end
	end

	// Stage 5: final y; this stage is the output register.
	sat_t  ay_c, ry_c;
	word_t rx_s5, ry_s5, rz_s5;
	logic  ovf_s5;

	always_comb begin
		ay_c = sat_add(y_s4, ty_s4);
		ry_c = sat_add(ay_c.val, ny_s4);
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			rx_s5  <= rx_s4;
			ry_s5  <= ry_c.val;
			rz_s5  <= rz_s4;
			ovf_s5 <= ovf_s4 | ay_c.ovf | ry_c.ovf;
		end
	end

	assign out_valid     = v_s5;
	assign out_x         = rx_s5;
	assign out_y         = ry_s5;
	assign out_z         = rz_s5;
	assign overflow_flag = ovf_s5;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted input word did not enter the first stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en2 |=> v_s1 && $stable(x_s1) && $stable(dxy_s1))
		else $error("first stage changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && ovf_s4 && en5 |=> out_valid && overflow_flag)
		else $error("saturation flag lost on the way to the output");
`endif

endmodule

`default_nettype wire

FILE: bench/lorenz63_euler_step_checker.sv
// Checker for the Lorenz-63 Euler step unit: watches the register port and both word channels.
// Predicts every output word in saturating Q8.24 arithmetic and compares it field by field.
// Depends on l63eul_pkg for the number format and the register indexes.

module lorenz63_euler_step_checker #(
	parameter int WB = l63eul_pkg::DEFAULT_WORD_BITS,
	parameter int FB = l63eul_pkg::DEFAULT_FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  l63eul_pkg::cfg_index_t cfg_index,
	input  logic        [WB-1:0]   cfg_data,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic signed [WB-1:0]   in_x,
	input  logic signed [WB-1:0]   in_y,
	input  logic signed [WB-1:0]   in_z,
	input  logic signed [WB-1:0]   noise_x,
	input  logic signed [WB-1:0]   noise_y,
	input  logic signed [WB-1:0]   noise_z,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic signed [WB-1:0]   out_x,
	input  logic signed [WB-1:0]   out_y,
	input  logic signed [WB-1:0]   out_z,
	input  logic                   overflow_flag,
	output int                     fail_count,
	output int                     pending
);
	import l63eul_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint WORD_MAX = (longint'(1) <<< (WB - 1)) - 1;
	localparam longint WORD_MIN = -WORD_MAX - 1;
	localparam longint UNIT = longint'(1) <<< FB;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic signed [WB-1:0] x;
		logic signed [WB-1:0] y;
		logic signed [WB-1:0] z;
		logic                 ovf;
	} euler_word_t;

	euler_word_t awaited_words[$];
	logic signed [WB-1:0] sigma_q;
	logic signed [WB-1:0] rho_q;
	logic signed [WB-1:0] beta_q;
	logic        [WB-2:0] dt_q;
	bit sat_hit;
	int mismatches = 0;

	function automatic longint sat_word(input longint v);
		if (v > WORD_MAX) begin
			sat_hit = 1'b1;
			return WORD_MAX;
		end
		if (v < WORD_MIN) begin
			sat_hit = 1'b1;
			return WORD_MIN;
		end
		return v;
	endfunction

	// The shift rounds towards minus infinity, as the datapath does.
	function automatic longint sat_product(input longint a, input longint b);
		return sat_word((a * b) >>> FB);
	endfunction

	function automatic euler_word_t euler_step(input logic signed [WB-1:0] px,
			input logic signed [WB-1:0] py, input logic signed [WB-1:0] pz,
			input logic signed [WB-1:0] nx, input logic signed [WB-1:0] ny,
			input logic signed [WB-1:0] nz);
		longint x, y, z, sg, rh, bt, dt, rx, ry, rz, ex, ey, ez;
		euler_word_t res;
		x = longint'(px);
		y = longint'(py);
		z = longint'(pz);
		ex = longint'(nx);
		ey = longint'(ny);
		ez = longint'(nz);
		sg = longint'(sigma_q);
		rh = longint'(rho_q);
		bt = longint'(beta_q);
		dt = longint'(dt_q);
		sat_hit = 1'b0;
		rx = sat_product(sat_product(sg, sat_word(y - x)), dt);
		rx = sat_word(sat_word(x + rx) + ex);
		ry = sat_word(sat_product(x, sat_word(rh - z)) - y);
		ry = sat_word(sat_word(y + sat_product(ry, dt)) + ey);
		rz = sat_word(sat_product(x, y) - sat_product(bt, z));
		rz = sat_word(sat_word(z + sat_product(rz, dt)) + ez);
		res.x = rx[WB-1:0];
		res.y = ry[WB-1:0];
		res.z = rz[WB-1:0];
		res.ovf = sat_hit;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		euler_word_t want;
		euler_word_t fresh;
		if (!arst_n) begin
			sigma_q = WB'(10 * UNIT);
			rho_q = WB'(28 * UNIT);
			beta_q = WB'((16 * UNIT + 3) / 6);
			dt_q = (WB-1)'((UNIT + 100) / 200);
			awaited_words.delete();
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_SIGMA: sigma_q = cfg_data;
					CFG_RHO:   rho_q = cfg_data;
					CFG_BETA:  beta_q = cfg_data;
					CFG_STEP:  dt_q = cfg_data[WB-2:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (awaited_words.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: unexpected output word x=%0d y=%0d z=%0d ovf=%0b",
							$realtime, out_x, out_y, out_z, overflow_flag);
				end else begin
					want = awaited_words.pop_front();
					if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
							overflow_flag !== want.ovf) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%0t: output word mismatch: ", $realtime,
								"expected x=%0d y=%0d z=%0d ovf=%0b, ",
								want.x, want.y, want.z, want.ovf,
								"got x=%0d y=%0d z=%0d ovf=%0b",
								out_x, out_y, out_z, overflow_flag);
					end
				end
			end
			if (in_valid && in_ready) begin
				fresh = euler_step(in_x, in_y, in_z, noise_x, noise_y, noise_z);
				awaited_words = {awaited_words, fresh};
			end
			pending <= awaited_words.size();
		end
		fail_count <= mismatches;
	end

endmodule

FILE: bench/tb_lorenz63_euler_step_unit.sv
// Testbench top for the Lorenz-63 Euler step unit: clock, reset, stimulus and verdict.
// Drives directed and random words under several register settings with random stalls.
// Depends on l63eul_pkg, the unit itself and lorenz63_euler_step_checker.

module tb_lorenz63_euler_step_unit;
	import l63eul_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WB = DEFAULT_WORD_BITS;
	localparam int ONE = 1 << DEFAULT_FRAC_BITS;
	localparam int PIPE_LATENCY = 5;
	localparam int IDLE_PCT = 26;
	localparam int HOLD_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 215;

	typedef logic signed [WB-1:0] word_t;

	localparam word_t WMAX = {1'b0, {(WB-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(WB-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	cfg_index_t cfg_index = CFG_SIGMA;
	logic [WB-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	word_t in_x = '0;
	word_t in_y = '0;
	word_t in_z = '0;
	word_t noise_x = '0;
	word_t noise_y = '0;
	word_t noise_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	word_t out_x, out_y, out_z;
	logic overflow_flag;

	int fail_count;
	int pending;
	int hold_asked = 0;
	int hold_given = 0;
	int hold_left = 0;
	bit steady = 1'b0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	lorenz63_euler_step_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_x          (in_x),
		.in_y          (in_y),
		.in_z          (in_z),
		.noise_x       (noise_x),
		.noise_y       (noise_y),
		.noise_z       (noise_z),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_z         (out_z),
		.overflow_flag (overflow_flag)
	);

	lorenz63_euler_step_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_x          (in_x),
		.in_y          (in_y),
		.in_z          (in_z),
		.noise_x       (noise_x),
		.noise_y       (noise_y),
		.noise_z       (noise_z),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_z         (out_z),
		.overflow_flag (overflow_flag),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// A hold-off request keeps the receiver stalled until hold_left, loaded from HOLD_CYCLES, counts down to zero.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_given != hold_asked) begin
			hold_given <= hold_asked;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic word_t pick_extreme();
		case ($urandom_range(6))
			0: return WMAX;
			1: return WMIN;
			2: return 0;
			3: return 1;
			4: return -1;
			5: return ONE;
			default: return -ONE;
		endcase
	endfunction

	function automatic word_t pick_coord();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return word_t'($urandom_range(0, 80 * ONE)) - 40 * ONE;
		if (roll < 88)
			return word_t'($urandom);
		return pick_extreme();
	endfunction

	function automatic word_t pick_noise();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return word_t'($urandom_range(0, ONE)) - ONE / 2;
		if (roll < 90)
			return word_t'($urandom);
		return pick_extreme();
	endfunction

	task automatic send_word(input word_t x, input word_t y, input word_t z,
			input word_t nx, input word_t ny, input word_t nz);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_x <= x;
		in_y <= y;
		in_z <= z;
		noise_x <= nx;
		noise_y <= ny;
		noise_z <= nz;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic apply_setting(input logic [WB-1:0] sigma, input logic [WB-1:0] rho,
			input logic [WB-1:0] beta, input logic [WB-1:0] dt);
		cfg_index_t order [4];
		logic [WB-1:0] values [4];
		order = '{CFG_SIGMA, CFG_RHO, CFG_BETA, CFG_STEP};
		values = '{sigma, rho, beta, dt};
		drain_results();
		for (int i = 0; i < 4; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= values[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default parameters: saturation in every stage, floor rounding and bit patterns.
		send_word(0, 0, 0, 0, 0, 0);
		send_word(ONE, ONE, ONE, 0, 0, 0);
		send_word(-11 * ONE / 2, 13 * ONE / 4, 20 * ONE, ONE / 8, -ONE / 8, 3);
		send_word(WMAX, WMIN, 0, 0, 0, 0);
		send_word(WMIN, WMAX, 0, 0, 0, 0);
		send_word(WMAX, WMAX, WMAX, 0, 0, 0);
		send_word(WMIN, WMIN, WMIN, 0, 0, 0);
		send_word(WMAX, 0, WMIN, 0, 0, 0);
		send_word(0, 0, 0, WMAX, WMIN, WMAX);
		send_word(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX);
		send_word(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN);
		send_word(-1, 3, -5, 0, 0, 0);
		send_word(-1, -1, -1, -1, -1, -1);
		send_word(32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
			32'h5555_5555, 32'h5555_5555, 32'h5555_5555);
		send_word(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
			32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
		send_word(ONE, -ONE, 28 * ONE, 0, 0, 0);
		send_word(-ONE, ONE, -28 * ONE, WMIN, 0, WMAX);

		for (int phase = 1; phase <= PHASES; phase++) begin
			case (phase)
				1: apply_setting(10 * ONE, 28 * ONE, (16 * ONE + 3) / 6, (ONE + 100) / 200);
				2: apply_setting(WMAX, WMAX, WMAX, 32'hFFFF_FFFF);
				3: apply_setting(WMIN, WMIN, WMIN, 0);
				4: apply_setting(-3 * ONE, ONE / 2, -ONE, ONE);
				5: apply_setting(10 * ONE, 28 * ONE, 3 * ONE, 1);
				default: apply_setting($urandom, $urandom, $urandom, $urandom);
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 1 && n == 0)
					steady <= 1'b1;
				if (phase == 1 && n == 120)
					steady <= 1'b0;
				if (phase == 4 && n == 50)
					hold_asked <= hold_asked + 1;
				if (phase == 6 && n == 100)
					drain_results();
				send_word(pick_coord(), pick_coord(), pick_coord(),
					pick_noise(), pick_noise(), pick_noise());
			end
		end

		drain_results();
		repeat (4 * PIPE_LATENCY) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
rtl/l63eul_pkg.sv
rtl/lorenz63_euler_step_unit.sv
bench/lorenz63_euler_step_checker.sv
bench/tb_lorenz63_euler_step_unit.sv
